### rtl/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, constants and the quarter-sine table function of the
// crossfade mixer.
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int unsigned DEF_CHANNELS        = 2;
    localparam int unsigned DEF_SAMPLE_RATE     = 48000;
    localparam int unsigned DEF_SINE_TABLE_BITS = 8;

    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned POS_W    = 18;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned CLIP_W   = 12;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 18;
    localparam int unsigned LIN_QBITS  = 15;

    localparam logic [GAIN_W-1:0] Q15_ONE  = 16'd32768;
    localparam logic [CLIP_W-1:0] CLIP_MAX = 12'd4095;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTGOING_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INCOMING_GAIN = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_WSEL,
        S_DIV,
        S_LIN,
        S_SIN_RD,
        S_SIN_MUL,
        S_COS_RD,
        S_COS_MUL,
        S_GAIN,
        S_PROD,
        S_SUM,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic wsel;
        logic div_step;
        logic lin;
        logic sin_rd;
        logic sin_mul;
        logic cos_rd;
        logic cos_mul;
        logic gain;
        logic prod;
        logic sum;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic frame_start;
        logic weight_fixed;
        logic curve;
        logic div_done;
        logic out_free;
    } t_status;

    // quarter-sine entry k of a table with 2^tb intervals, Q15
    function automatic logic [GAIN_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned tb);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        a    = (longint'(k) * 64'd1686629713) >> tb;
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        // Taylor terms x^3 .. x^11, alternating sign
        term = ((term * a2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * a2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * a2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * a2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * a2) >> 30) / 64'd110;
        sum  = sum - term;
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32768) begin
            v = 64'd32768;
        end
        return v[GAIN_W-1:0];
    endfunction

endpackage

### rtl/acm_in_if.sv
// ----------------------------------------------------------------------------
// acm_in_if
// Sample channel: one outgoing and one incoming sample with block marks.
// ----------------------------------------------------------------------------
interface acm_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   outgoing_sample;
    logic signed [23:0]   incoming_sample;
    logic                 block_first;
    logic        [17:0]   start_position;
    logic                 block_last;

    modport source (output valid, outgoing_sample, incoming_sample, block_first,
                    start_position, block_last, input ready);
    modport sink   (input valid, outgoing_sample, incoming_sample, block_first,
                    start_position, block_last, output ready);
endinterface

### rtl/acm_out_if.sv
// ----------------------------------------------------------------------------
// acm_out_if
// Result channel: mixed sample, clip flag and count, block end mark.
// ----------------------------------------------------------------------------
interface acm_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   mixed_sample;
    logic                 was_clipped;
    logic        [11:0]   clip_total;
    logic                 block_end;

    modport source (output valid, mixed_sample, was_clipped, clip_total, block_end,
                    input ready);
    modport sink   (input valid, mixed_sample, was_clipped, clip_total, block_end,
                    output ready);
endinterface

### rtl/acm_cfg_if.sv
// ----------------------------------------------------------------------------
// acm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface acm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [17:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/acm_ctrl.sv
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer of the mixer: steps one sample through weight update, gain,
// product, sum and output.
// ----------------------------------------------------------------------------
module acm_ctrl
    import acm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_WSEL;
            end
            S_WSEL: begin
                o_cmd.wsel = 1'b1;
                if (!i_status.frame_start || i_status.weight_fixed) begin
                    n_state = S_GAIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = i_status.curve ? S_SIN_RD : S_LIN;
                end
            end
            S_LIN: begin
                o_cmd.lin = 1'b1;
                n_state   = S_GAIN;
            end
            S_SIN_RD: begin
                o_cmd.sin_rd = 1'b1;
                n_state      = S_SIN_MUL;
            end
            S_SIN_MUL: begin
                o_cmd.sin_mul = 1'b1;
                n_state       = S_COS_RD;
            end
            S_COS_RD: begin
                o_cmd.cos_rd = 1'b1;
                n_state      = S_COS_MUL;
            end
            S_COS_MUL: begin
                o_cmd.cos_mul = 1'b1;
                n_state       = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/acm_datapath.sv
// ----------------------------------------------------------------------------
// acm_datapath
// Registers, fade divider, sine table, gain and mix arithmetic of the mixer.
// ----------------------------------------------------------------------------
module acm_datapath
    import acm_pkg::*;
#(
    parameter int unsigned CHANNELS        = DEF_CHANNELS,
    parameter int unsigned SAMPLE_RATE     = DEF_SAMPLE_RATE,
    parameter int unsigned SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    // sample fields
    input  logic signed [SAMPLE_W-1:0]  i_outgoing_sample,
    input  logic signed [SAMPLE_W-1:0]  i_incoming_sample,
    input  logic                        i_block_first,
    input  logic        [POS_W-1:0]     i_start_position,
    input  logic                        i_block_last,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // result
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [SAMPLE_W-1:0]  o_mixed_sample,
    output logic                        o_was_clipped,
    output logic        [CLIP_W-1:0]    o_clip_total,
    output logic                        o_block_end
);

    localparam int unsigned TAB_N   = 1 << SINE_TABLE_BITS;
    localparam int unsigned IDX_W   = SINE_TABLE_BITS + 1;
    localparam int unsigned EQ_QB   = SINE_TABLE_BITS + 8;
    localparam int unsigned QW      = (EQ_QB > LIN_QBITS) ? EQ_QB : LIN_QBITS;
    localparam int unsigned CNT_W   = $clog2(QW + 1);
    localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned MAX_F   = 5 * SAMPLE_RATE;
    localparam int unsigned LEN_W   = POS_W + 2;
    localparam int unsigned PG_W    = 31;
    localparam int unsigned PROD_W  = SAMPLE_W + PG_W + 1;
    localparam int unsigned ACC_W   = PROD_W + 1;
    localparam int unsigned Q_W     = ACC_W - 30;
    localparam logic [LEN_W-1:0] MAX_FADE = LEN_W'(MAX_F);
    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [IDX_W-1:0] TAB_NI   = IDX_W'(TAB_N);

    // constant quarter-sine table
    logic [GAIN_W-1:0] w_sine [0:TAB_N];
    for (genvar g = 0; g <= TAB_N; g++) begin : g_sine
        assign w_sine[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    // configuration registers
    logic [POS_W-1:0]  r_fade_length;
    logic              r_curve_mode;
    logic [GAIN_W-1:0] r_outgoing_gain;
    logic [GAIN_W-1:0] r_incoming_gain;

    // apply configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_length   <= '0;
            r_curve_mode    <= 1'b0;
            r_outgoing_gain <= Q15_ONE;
            r_incoming_gain <= Q15_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FADE_LENGTH:   r_fade_length   <= i_cfg_data[POS_W-1:0];
                REG_CURVE_MODE:    r_curve_mode    <= i_cfg_data[0];
                REG_OUTGOING_GAIN: r_outgoing_gain <= i_cfg_data[GAIN_W-1:0];
                REG_INCOMING_GAIN: r_incoming_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective fade length, capped at five seconds
    logic [POS_W-1:0] w_len;
    assign w_len = ({2'b00, r_fade_length} > MAX_FADE) ? MAX_F[POS_W-1:0] : r_fade_length;

    // captured sample fields
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [SAMPLE_W-1:0] r_b;
    logic                       r_first;
    logic [POS_W-1:0]           r_start;
    logic                       r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a     <= i_outgoing_sample;
            r_b     <= i_incoming_sample;
            r_first <= i_block_first;
            r_start <= i_start_position;
            r_last  <= i_block_last;
        end
    end

    // frame state
    logic [POS_W-1:0]  r_pos;
    logic [CH_W-1:0]   r_ch;
    logic [CLIP_W-1:0] r_clip;
    logic [GAIN_W-1:0] r_wo;
    logic [GAIN_W-1:0] r_wi;

    // divider state
    logic [POS_W-1:0]  r_rem;
    logic [QW-1:0]     r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_div_curve;
    logic [POS_W:0]    w_shift;
    logic              w_ge;
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, w_len};

    // table interpolation
    logic [SINE_TABLE_BITS-1:0] w_k;
    logic [IDX_W-1:0]           w_kx;
    logic [7:0]                 w_r;
    logic [GAIN_W-1:0]          r_ta;
    logic [GAIN_W-1:0]          r_tb;
    logic [25:0]                w_interp;
    assign w_k      = r_quo[EQ_QB-1:8];
    assign w_kx     = {1'b0, w_k};
    assign w_r      = r_quo[7:0];
    assign w_interp = 26'(r_ta) * 26'(9'd256 - {1'b0, w_r}) + 26'(r_tb) * 26'({1'b0, w_r})
                    + 26'd128;

    // gain, product and sum registers
    logic [GAIN_W-1:0]        w_go;
    logic [GAIN_W-1:0]        w_gi;
    logic [PG_W-1:0]          r_pgo;
    logic [PG_W-1:0]          r_pgi;
    logic signed [PROD_W-1:0] r_po;
    logic signed [PROD_W-1:0] r_pi;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [Q_W-1:0]    w_q;
    logic                     w_hi;
    logic                     w_lo;
    assign w_go  = (r_outgoing_gain > Q15_ONE) ? Q15_ONE : r_outgoing_gain;
    assign w_gi  = (r_incoming_gain > Q15_ONE) ? Q15_ONE : r_incoming_gain;
    assign w_acc = ACC_W'(r_po) + ACC_W'(r_pi) + (ACC_W'(1) <<< 29);
    assign w_q   = Q_W'(w_acc >>> 30);
    assign w_hi  = w_q > Q_W'(8388607);
    assign w_lo  = w_q < -Q_W'(8388608);

    logic signed [SAMPLE_W-1:0] r_mix;
    logic                       r_clipped;

    // frame, weight and clip bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ch   <= '0;
            r_clip <= '0;
            r_wo   <= '0;
            r_wi   <= '0;
        end else begin
            if (i_cmd.load && r_first) begin
                r_pos  <= r_start;
                r_ch   <= '0;
                r_clip <= '0;
            end
            if (i_cmd.wsel && r_ch == '0) begin
                if (r_pos >= w_len) begin
                    r_wo <= '0;
                    r_wi <= Q15_ONE;
                end else if (r_pos == '0) begin
                    r_wo <= Q15_ONE;
                    r_wi <= '0;
                end
            end
            if (i_cmd.lin) begin
                r_wi <= {1'b0, r_quo[LIN_QBITS-1:0]};
                r_wo <= Q15_ONE - {1'b0, r_quo[LIN_QBITS-1:0]};
            end
            if (i_cmd.sin_mul) begin
                r_wi <= w_interp[23:8];
            end
            if (i_cmd.cos_mul) begin
                r_wo <= w_interp[23:8];
            end
            if (i_cmd.sum && (w_hi || w_lo) && r_clip < CLIP_MAX) begin
                r_clip <= r_clip + 1'b1;
            end
            // advance channel, and position at frame end
            if (i_cmd.emit) begin
                if (r_ch >= LAST_CH) begin
                    r_ch <= '0;
                    if (r_pos < w_len) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end else begin
                    r_ch <= r_ch + 1'b1;
                end
            end
        end
    end

    // restoring division of position by length, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.wsel) begin
            r_rem       <= r_pos;
            r_quo       <= '0;
            r_div_curve <= r_curve_mode;
            r_cnt       <= r_curve_mode ? CNT_W'(EQ_QB) : CNT_W'(LIN_QBITS);
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_rem <= w_ge ? POS_W'(w_shift - {1'b0, w_len}) : w_shift[POS_W-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // table reads for sine then cosine
    always_ff @(posedge i_clk) begin
        if (i_cmd.sin_rd) begin
            r_ta <= w_sine[w_kx];
            r_tb <= w_sine[w_kx + 1'b1];
        end else if (i_cmd.cos_rd) begin
            r_ta <= w_sine[TAB_NI - w_kx];
            r_tb <= w_sine[TAB_NI - w_kx - 1'b1];
        end
    end

    // weight times gain, then sample times scaled weight
    always_ff @(posedge i_clk) begin
        if (i_cmd.gain) begin
            r_pgo <= PG_W'(r_wo) * PG_W'(w_go);
            r_pgi <= PG_W'(r_wi) * PG_W'(w_gi);
        end
        if (i_cmd.prod) begin
            r_po <= PROD_W'(r_a) * $signed({1'b0, r_pgo});
            r_pi <= PROD_W'(r_b) * $signed({1'b0, r_pgi});
        end
        if (i_cmd.sum) begin
            r_mix     <= w_hi ? 24'sd8388607 : (w_lo ? -24'sd8388608 : w_q[SAMPLE_W-1:0]);
            r_clipped <= w_hi || w_lo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_mixed_sample <= r_mix;
            o_was_clipped  <= r_clipped;
            o_clip_total   <= r_clip;
            o_block_end    <= r_last;
        end
    end

    assign o_status.frame_start  = r_ch == '0;
    assign o_status.weight_fixed = (r_pos >= w_len) || (r_pos == '0);
    assign o_status.curve        = r_div_curve;
    assign o_status.div_done     = r_cnt == CNT_W'(1);
    assign o_status.out_free     = !o_out_valid || i_out_ready;

endmodule

### rtl/audio_crossfade_mixer_unit.sv
// ----------------------------------------------------------------------------
// audio_crossfade_mixer_unit
// Linear or equal-power crossfade of two interleaved audio streams.
// ----------------------------------------------------------------------------
// One sample is processed at a time. A sample that is not the first of a
// frame passes through the load, weight select, gain, product, sum and
// output states. The first sample of a frame also updates the weights:
// fixed at the start or end of the fade, otherwise the restoring divider
// forms 15 quotient bits (linear) or SINE_TABLE_BITS+8 (equal power), then
// a linear step or sine read, sine multiply, cosine read and cosine multiply.
// The sequencer passes through idle before the next sample, and waits in its
// output state while the sink holds off a full output register. The output
// register lets a result wait for the sink while the next one is accepted.
module audio_crossfade_mixer_unit
    import acm_pkg::*;
#(
    parameter int unsigned CHANNELS        = DEF_CHANNELS,
    parameter int unsigned SAMPLE_RATE     = DEF_SAMPLE_RATE,
    parameter int unsigned SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    acm_in_if.sink    i_in,
    acm_out_if.source o_out,
    acm_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    acm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    acm_datapath #(
        .CHANNELS        (CHANNELS),
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_outgoing_sample (i_in.outgoing_sample),
        .i_incoming_sample (i_in.incoming_sample),
        .i_block_first     (i_in.block_first),
        .i_start_position  (i_in.start_position),
        .i_block_last      (i_in.block_last),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_mixed_sample    (o_out.mixed_sample),
        .o_was_clipped     (o_out.was_clipped),
        .o_clip_total      (o_out.clip_total),
        .o_block_end       (o_out.block_end)
    );

endmodule

### rtl/acm_checker.sv
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks of the crossfade mixer, bound to the top level.
// ----------------------------------------------------------------------------
module acm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_mixed_sample,
    input logic        i_was_clipped,
    input logic [11:0] i_clip_total
);

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // clipped results sit at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_was_clipped |->
            (i_mixed_sample == 24'h7FFFFF || i_mixed_sample == 24'h800000))
        else $error("clipped sample not at full scale");

    // a clipped result is counted
    a_clip_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_was_clipped |-> i_clip_total != 12'd0)
        else $error("clip not counted");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind audio_crossfade_mixer_unit acm_checker u_acm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_mixed_sample (o_out.mixed_sample),
    .i_was_clipped  (o_out.was_clipped),
    .i_clip_total   (o_out.clip_total)
);
